>>> hw/rtl/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// csvfs_pkg
// shared types and constants of the csv field splitter
// ----------------------------------------------------------------------------
package csvfs_pkg;

	localparam logic [7:0] QUOTE_BYTE   = 8'd34;
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [7:0] SEP_RESET    = 8'd44;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_BYTE      = 2'd0,
		KIND_FIELD_END = 2'd1,
		KIND_LINE_END  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		MODE_START       = 3'd0,
		MODE_PLAIN       = 3'd1,
		MODE_QUOTED      = 3'd2,
		MODE_QUOTE_SEEN  = 3'd3,
		MODE_AFTER_QUOTE = 3'd4
	} mode_t;

	typedef enum logic {
		REG_SEP_PRIMARY   = 1'b0,
		REG_SEP_SECONDARY = 1'b1
	} reg_idx_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} token_t;

endpackage

>>> hw/rtl/csvfs_if.sv
// ----------------------------------------------------------------------------
// csvfs_text_if / csvfs_field_if
// valid/ready channels for text bytes and splitter results
// ----------------------------------------------------------------------------
interface csvfs_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface csvfs_field_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;

	modport source (output valid, output out_kind, output out_byte, input ready);
	modport sink (input valid, input out_kind, input out_byte, output ready);
endinterface

>>> hw/rtl/csvfs_front.sv
// ----------------------------------------------------------------------------
// csvfs_front
// accepts text bytes, tracks field/line state and forms result tokens
// ----------------------------------------------------------------------------
module csvfs_front
	import csvfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	csvfs_text_if.sink        text_ch,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_wdata,
	input  logic              queue_full,
	output logic              push,
	output token_t            token
);

	logic [7:0] sep_a_q;
	logic [7:0] sep_b_q;
	mode_t      mode_q;
	logic       line_open_q;

	mode_t      mode_d;
	logic       line_open_d;
	logic       has_result;
	logic       accept;
	logic       is_sep;
	logic       closes;
	logic [7:0] b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_a_q <= SEP_RESET;
			sep_b_q <= SEP_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SEP_PRIMARY:   sep_a_q <= cfg_wdata;
				REG_SEP_SECONDARY: sep_b_q <= cfg_wdata;
				default:           sep_a_q <= sep_a_q;
			endcase
		end
	end

	assign text_ch.ready = !queue_full;
	assign accept        = text_ch.valid && text_ch.ready;
	assign b             = text_ch.in_byte;
	assign is_sep        = (b == sep_a_q) || (b == sep_b_q);
	assign closes        = text_ch.end_of_text || (b == NEWLINE_BYTE);

	always_comb begin
		mode_d      = mode_q;
		line_open_d = line_open_q;
		has_result  = 1'b0;
		token.kind  = KIND_BYTE;
		token.data  = b;
		if (closes) begin
			mode_d      = MODE_START;
			line_open_d = 1'b0;
			has_result  = line_open_q;
			token.kind  = KIND_LINE_END;
			token.data  = 8'd0;
		end else begin
			line_open_d = 1'b1;
			unique case (mode_q)
				MODE_START: begin
					if (b == QUOTE_BYTE) begin
						mode_d = MODE_QUOTED;
					end else if (is_sep) begin
						has_result = 1'b1;
						token.kind = KIND_FIELD_END;
						token.data = 8'd0;
					end else begin
						mode_d     = MODE_PLAIN;
						has_result = 1'b1;
					end
				end
				MODE_QUOTED: begin
					if (b == QUOTE_BYTE) begin
						mode_d = MODE_QUOTE_SEEN;
					end else begin
						has_result = 1'b1;
					end
				end
				MODE_QUOTE_SEEN: begin
					has_result = 1'b1;
					if (b == QUOTE_BYTE) begin
						mode_d = MODE_QUOTED;
					end else if (is_sep) begin
						mode_d     = MODE_START;
						token.kind = KIND_FIELD_END;
						token.data = 8'd0;
					end else begin
						mode_d = MODE_AFTER_QUOTE;
					end
				end
				default: begin
					has_result = 1'b1;
					if (is_sep) begin
						mode_d     = MODE_START;
						token.kind = KIND_FIELD_END;
						token.data = 8'd0;
					end else if (mode_q != MODE_AFTER_QUOTE) begin
						mode_d = MODE_PLAIN;
					end
				end
			endcase
		end
	end

	assign push = accept && has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_START;
			line_open_q <= 1'b0;
		end else if (accept) begin
			mode_q      <= mode_d;
			line_open_q <= line_open_d;
		end
	end

	a_close_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && closes |=> mode_q == MODE_START && !line_open_q)
		else $error("line close did not return to field start");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !queue_full)
		else $error("push while queue full");

	a_open_after_byte: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !closes |=> line_open_q)
		else $error("line not open after a content byte");

endmodule

>>> hw/rtl/csvfs_queue.sv
// ----------------------------------------------------------------------------
// csvfs_queue
// short token queue between the classifier and the output stage
// ----------------------------------------------------------------------------
module csvfs_queue
	import csvfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  token_t     wr_token,
	input  logic       pop,
	output logic       full,
	output logic       not_empty,
	output token_t     rd_token
);

	token_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;
	logic                  do_pop;

	assign full      = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_token  = slot_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("queue count out of range");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == QUEUE_CW'(1) && do_pop && !push |=> !not_empty)
		else $error("queue not empty after last transfer out");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push && !do_pop |=> not_empty)
		else $error("queue empty after push");

endmodule

>>> hw/rtl/csvfs_back.sv
// ----------------------------------------------------------------------------
// csvfs_back
// output register that drives tokens onto the result channel
// ----------------------------------------------------------------------------
module csvfs_back
	import csvfs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  token_t        q_token,
	output logic          pop,
	csvfs_field_if.source field_ch
);

	logic   out_valid_q;
	token_t out_tok_q;

	assign pop = q_not_empty && (!out_valid_q || field_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || field_ch.ready) begin
			out_valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_tok_q <= q_token;
		end
	end

	assign field_ch.valid    = out_valid_q;
	assign field_ch.out_kind = out_tok_q.kind;
	assign field_ch.out_byte = out_tok_q.data;

	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_tok_q.kind != KIND_BYTE |-> out_tok_q.data == 8'd0)
		else $error("end mark with nonzero byte");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_tok_q.kind <= KIND_LINE_END)
		else $error("illegal result kind");

	a_load_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("output register not loaded after transfer from queue");

endmodule

>>> hw/rtl/csv_field_splitter_core.sv
// ----------------------------------------------------------------------------
// csv_field_splitter_core
// streaming csv field splitter, one text byte per transfer
// ----------------------------------------------------------------------------
// Takes one text byte (or an end-of-text mark) every clock cycle and gives at
// most one result per byte: a field byte, an end-of-field mark or an
// end-of-line mark. The classifier updates the field state in the cycle of
// the transfer, a two-entry queue holds results and an output register drives
// them. Input stalls while the queue is full, which happens only after the
// result side has stalled. The user must write separator registers 0 and 1
// through the cfg port only while the block is idle; the block does not
// enforce this.
// ----------------------------------------------------------------------------
module csv_field_splitter_core
	import csvfs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	csvfs_text_if.sink    text_ch,
	csvfs_field_if.source field_ch,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [7:0]    cfg_wdata
);

	logic       push;
	token_t     front_token;
	token_t     head_token;
	logic       queue_full;
	logic       queue_not_empty;
	logic       pop;

	csvfs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_ch    (text_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.queue_full (queue_full),
		.push       (push),
		.token      (front_token)
	);

	csvfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_token  (front_token),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.rd_token  (head_token)
	);

	csvfs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (queue_not_empty),
		.q_token     (head_token),
		.pop         (pop),
		.field_ch    (field_ch)
	);

endmodule
